### hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL modules.
// Each module that asserts provides clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside of reset
`define L2H_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition that must never be true outside of reset
`define L2H_NEVER(lbl, cond, msg) \
	`L2H_ASSERT(lbl, !(cond), msg)

`endif

### hw/rtl/l2h_pkg.sv
`default_nettype none

package l2h_pkg;

	// Initial value of lanes a and b
	localparam logic [31:0] GOLDEN = 32'h9e3779b9;

	// Byte position of the last byte in a 12-byte block
	localparam logic [3:0] BLK_LAST = 4'd11;

	// Last row of the mix; one row runs per cycle
	localparam logic [3:0] MIX_LAST = 4'd8;

	// Default depth of the job queue between front and back
	localparam int L2H_QUEUE_DEPTH = 4;

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
	} lanes_t;

	// One unit of work handed from the front to the back
	typedef struct packed {
		logic        has_block;  // full 12-byte block to add and mix
		logic        is_final;   // finalize and emit after this job
		logic [31:0] wa;         // word for lane a
		logic [31:0] wb;         // word for lane b
		logic [31:0] wc;         // word for lane c (tail already shifted)
		logic [31:0] len;        // message length so far, mod 2^32
		logic [31:0] seed;       // seed sampled at message start
	} job_t;

	// One row of the lookup2 mix; the lane roles rotate a, b, c
	function automatic lanes_t mix_row(lanes_t l, logic [3:0] row);
		lanes_t r;
		r = l;
		case (row)
			4'd0: r.a = (l.a - l.b - l.c) ^ (l.c >> 13);
			4'd1: r.b = (l.b - l.c - l.a) ^ (l.a << 8);
			4'd2: r.c = (l.c - l.a - l.b) ^ (l.b >> 13);
			4'd3: r.a = (l.a - l.b - l.c) ^ (l.c >> 12);
			4'd4: r.b = (l.b - l.c - l.a) ^ (l.a << 16);
			4'd5: r.c = (l.c - l.a - l.b) ^ (l.b >> 5);
			4'd6: r.a = (l.a - l.b - l.c) ^ (l.c >> 3);
			4'd7: r.b = (l.b - l.c - l.a) ^ (l.a << 10);
			4'd8: r.c = (l.c - l.a - l.b) ^ (l.b >> 15);
			default: r = l;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/l2h_front.sv
`default_nettype none

module l2h_front
	import l2h_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [31:0] cfg_wdata,
	input  wire logic        in_valid,
	output      logic        in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        has_byte,
	input  wire logic        last,
	output      logic        push,
	output      job_t        job,
	input  wire logic        q_full
);

`include "assert_macros.svh"

	logic [31:0]      seed_reg_q;
	logic             msg_active_q;
	logic [31:0]      seed_msg_q;
	logic [3:0]       pos_q;
	logic [31:0]      len_q;
	logic [11:0][7:0] blk_q;

	logic             accept;
	logic [3:0]       pos_cur;
	logic [31:0]      len_cur;
	logic [31:0]      seed_cur;
	logic [11:0][7:0] blk_cur;
	logic [11:0][7:0] blk_new;
	logic [3:0]       pos_inc;
	logic [31:0]      len_new;
	logic             blk_full;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// Message state reads as fresh before the first transfer of a message
	always_comb begin
		pos_cur  = msg_active_q ? pos_q      : '0;
		len_cur  = msg_active_q ? len_q      : '0;
		seed_cur = msg_active_q ? seed_msg_q : seed_reg_q;
		blk_cur  = msg_active_q ? blk_q      : '0;
	end

	// Drop the byte into its slot of the block
	always_comb begin
		blk_new = blk_cur;
		for (int i = 0; i < 12; i++) begin
			if (has_byte && pos_cur == 4'(i)) begin
				blk_new[i] = data_byte;
			end
		end
		pos_inc  = pos_cur + {3'b000, has_byte};
		len_new  = len_cur + {31'd0, has_byte};
		blk_full = has_byte && (pos_cur == BLK_LAST);
	end

	// Job for the back: a full block, a final tail, or both
	always_comb begin
		push          = accept && (blk_full || last);
		job.has_block = blk_full;
		job.is_final  = last;
		job.wa        = blk_new[3:0];
		job.wb        = blk_new[7:4];
		// tail bytes for lane c sit one byte up; the length owns the low byte
		job.wc        = blk_full ? 32'(blk_new[11:8]) : {24'(blk_new[10:8]), 8'h00};
		job.len       = len_new;
		job.seed      = seed_cur;
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_reg_q   <= '0;
			msg_active_q <= 1'b0;
			pos_q        <= '0;
			len_q        <= '0;
		end else begin
			if (cfg_we) begin
				seed_reg_q <= cfg_wdata;
			end
			if (accept) begin
				msg_active_q <= !last;
				pos_q        <= blk_full ? 4'd0 : pos_inc;
				len_q        <= len_new;
			end
		end
	end

	// Block bytes and sampled seed
	always_ff @(posedge clk) begin
		if (accept) begin
			blk_q      <= blk_full ? '0 : blk_new;
			seed_msg_q <= seed_cur;
		end
	end

	`L2H_ASSERT(a_pos_range, pos_q <= BLK_LAST, "front: block position out of range")
	`L2H_ASSERT(a_push_ready, push |-> !q_full, "front: job pushed into a full queue")

endmodule

`default_nettype wire

### hw/rtl/l2h_queue.sv
`default_nettype none

module l2h_queue
	import l2h_pkg::*;
#(
	parameter int DEPTH = L2H_QUEUE_DEPTH
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire job_t wr_job,
	output      logic full,
	input  wire logic pop,
	output      job_t rd_job,
	output      logic empty
);

`include "assert_macros.svh"

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign full   = (cnt_q == CW'(DEPTH));
	assign empty  = (cnt_q == '0);
	assign rd_job = mem_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Job storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	`L2H_NEVER(a_no_underflow, pop && empty, "queue: pop while empty")
	`L2H_NEVER(a_no_overflow, push && full, "queue: push while full")

endmodule

`default_nettype wire

### hw/rtl/l2h_back.sv
`default_nettype none

module l2h_back
	import l2h_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire job_t        job,
	input  wire logic        q_empty,
	output      logic        pop,
	output      logic        out_valid,
	input  wire logic        out_ready,
	output      logic [31:0] hash_value
);

`include "assert_macros.svh"

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MIX  = 4'b0010,
		ST_ADD  = 4'b0100,
		ST_EMIT = 4'b1000
	} back_state_t;

	back_state_t state_q;
	back_state_t state_nx;
	logic [3:0]  row_q;
	logic [3:0]  row_nx;
	logic        fresh_q;
	logic        fresh_nx;
	logic        pass2_q;
	logic        pass2_nx;
	logic        fin_q;
	logic        fin_nx;
	logic        out_valid_q;
	logic        out_valid_nx;
	logic        emit;

	lanes_t      lanes_q;
	lanes_t      lanes_nx;
	lanes_t      base;
	logic [31:0] len_q;
	logic [31:0] hash_q;

	assign pop        = (state_q == ST_IDLE) && !q_empty;
	assign emit       = (state_q == ST_EMIT) && (!out_valid_q || out_ready);
	assign out_valid  = out_valid_q;
	assign hash_value = hash_q;

	// Lanes restart from the constants and the message seed
	always_comb begin
		if (fresh_q) begin
			base.a = GOLDEN;
			base.b = GOLDEN;
			base.c = job.seed;
		end else begin
			base = lanes_q;
		end
	end

	// Sequencer: load, nine mix rows, optional length add and second mix, emit on a final job
	always_comb begin
		state_nx     = state_q;
		row_nx       = row_q;
		fresh_nx     = fresh_q;
		pass2_nx     = pass2_q;
		fin_nx       = fin_q;
		lanes_nx     = lanes_q;
		out_valid_nx = out_valid_q && !out_ready;
		case (state_q)
			ST_IDLE: begin
				if (!q_empty) begin
					lanes_nx.a = base.a + job.wa;
					lanes_nx.b = base.b + job.wb;
					if (job.has_block) begin
						lanes_nx.c = base.c + job.wc;
					end else begin
						lanes_nx.c = base.c + job.wc + job.len;
					end
					pass2_nx = job.has_block && job.is_final;
					fin_nx   = job.is_final;
					fresh_nx = 1'b0;
					row_nx   = '0;
					state_nx = ST_MIX;
				end
			end
			ST_MIX: begin
				lanes_nx = mix_row(lanes_q, row_q);
				if (row_q == MIX_LAST) begin
					if (pass2_q) begin
						state_nx = ST_ADD;
					end else if (fin_q) begin
						state_nx = ST_EMIT;
					end else begin
						state_nx = ST_IDLE;
					end
				end else begin
					row_nx = row_q + 1'b1;
				end
			end
			ST_ADD: begin
				// full block ended the message: length alone goes into c
				lanes_nx.c = lanes_q.c + len_q;
				pass2_nx   = 1'b0;
				row_nx     = '0;
				state_nx   = ST_MIX;
			end
			ST_EMIT: begin
				if (emit) begin
					out_valid_nx = 1'b1;
					fresh_nx     = 1'b1;
					state_nx     = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			row_q       <= '0;
			fresh_q     <= 1'b1;
			pass2_q     <= 1'b0;
			fin_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_nx;
			row_q       <= row_nx;
			fresh_q     <= fresh_nx;
			pass2_q     <= pass2_nx;
			fin_q       <= fin_nx;
			out_valid_q <= out_valid_nx;
		end
	end

	// Lane and result datapath
	always_ff @(posedge clk) begin
		lanes_q <= lanes_nx;
		if (pop) begin
			len_q <= job.len;
		end
		if (emit) begin
			hash_q <= lanes_q.c;
		end
	end

	`L2H_ASSERT(a_row_range, (state_q == ST_MIX) |-> (row_q <= MIX_LAST),
		"back: mix row out of range")
	`L2H_ASSERT(a_emit_origin, $rose(out_valid_q) |-> $past(state_q == ST_EMIT),
		"back: result raised outside the emit state")

endmodule

`default_nettype wire

### hw/rtl/lookup2_hash32_engine_top.sv
// Channel   Dir  Transfer when             Payload
// s_axis    in   s_axis_tvalid & tready    tdata=data_byte, tuser=has_byte, tlast=last
// m_axis    out  m_axis_tvalid & tready    tdata=hash_value
// cfg       in   cfg_we                    cfg_wdata=seed
//
// The front takes one byte per cycle; it stalls only when the job queue is full.
// The back loads each job and runs nine mix rows; when a full block ends the message it
// adds the length and runs the nine rows again, and a final job then waits to emit.
// Long messages run at one byte per cycle while the job queue has room.
// arst_n clears all control state; the seed resets to zero.
// A result waits in the output register while the back goes on with queued jobs.
`default_nettype none

module lookup2_hash32_engine_top
	import l2h_pkg::*;
#(
	parameter int QUEUE_DEPTH = L2H_QUEUE_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [31:0] cfg_wdata,
	input  wire logic        s_axis_tvalid,
	output      logic        s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  wire logic        s_axis_tuser,   // [0] has_byte
	input  wire logic        s_axis_tlast,
	output      logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output      logic [31:0] m_axis_tdata    // [31:0] hash_value
);

	logic push;
	logic pop;
	logic q_full;
	logic q_empty;
	job_t wr_job;
	job_t rd_job;

	// Byte gathering and job building
	l2h_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.data_byte (s_axis_tdata),
		.has_byte  (s_axis_tuser),
		.last      (s_axis_tlast),
		.push      (push),
		.job       (wr_job),
		.q_full    (q_full)
	);

	// Job queue between front and back
	l2h_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (wr_job),
		.full   (q_full),
		.pop    (pop),
		.rd_job (rd_job),
		.empty  (q_empty)
	);

	// Mixing and result
	l2h_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job        (rd_job),
		.q_empty    (q_empty),
		.pop        (pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.hash_value (m_axis_tdata)
	);

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
`default_nettype none

module tb_top;

	localparam logic [31:0] GOLDEN_RATIO = 32'h9e3779b9;
	// Quiet time before a seed write: a full queue of blocks plus the final emit
	localparam int SETTLE_CYCLES = 150;
	localparam int CYCLE_LIMIT = 300000;
	localparam int RANDOM_ITEMS = 420;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [31:0] cfg_wdata;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;   // [7:0] data_byte
	logic        s_axis_tuser;   // [0] has_byte
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;   // [31:0] hash_value

	// Predictor state
	logic [31:0] seed_reg = 32'd0;
	logic [31:0] lane_a;
	logic [31:0] lane_b;
	logic [31:0] lane_c;
	logic [31:0] msg_len;
	int          blk_pos;
	logic [7:0]  blk_buf [12];
	bit          in_msg = 1'b0;

	logic [31:0] pending_hashes [$];
	int          fail_count = 0;
	int          items_sent = 0;
	int          cycle_count = 0;
	bit          gaps_on = 1'b1;

	lookup2_hash32_engine_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #2 clk = ~clk;

	// Run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Three-lane scramble, rows in order
	function automatic void lookup2_mix();
		lane_a = (lane_a - lane_b - lane_c) ^ (lane_c >> 13);
		lane_b = (lane_b - lane_c - lane_a) ^ (lane_a << 8);
		lane_c = (lane_c - lane_a - lane_b) ^ (lane_b >> 13);
		lane_a = (lane_a - lane_b - lane_c) ^ (lane_c >> 12);
		lane_b = (lane_b - lane_c - lane_a) ^ (lane_a << 16);
		lane_c = (lane_c - lane_a - lane_b) ^ (lane_b >> 5);
		lane_a = (lane_a - lane_b - lane_c) ^ (lane_c >> 3);
		lane_b = (lane_b - lane_c - lane_a) ^ (lane_a << 10);
		lane_c = (lane_c - lane_a - lane_b) ^ (lane_b >> 15);
	endfunction

	// Fold one accepted transfer into the running hash; queue the hash on last
	function automatic void hash_predict(logic [7:0] data_byte, logic has_byte, logic last);
		int i;
		// lanes load on the first transfer of a message, seed sampled here
		if (!in_msg) begin
			lane_a = GOLDEN_RATIO;
			lane_b = GOLDEN_RATIO;
			lane_c = seed_reg;
			msg_len = 32'd0;
			blk_pos = 0;
			in_msg = 1'b1;
		end
		if (has_byte) begin
			blk_buf[blk_pos] = data_byte;
			blk_pos++;
			msg_len++;
			// full block: add little-endian words and mix, even at message end
			if (blk_pos == 12) begin
				lane_a += {blk_buf[3], blk_buf[2], blk_buf[1], blk_buf[0]};
				lane_b += {blk_buf[7], blk_buf[6], blk_buf[5], blk_buf[4]};
				lane_c += {blk_buf[11], blk_buf[10], blk_buf[9], blk_buf[8]};
				lookup2_mix();
				blk_pos = 0;
			end
		end
		if (last) begin
			lane_c += msg_len;
			// tail bytes 8..10 sit one byte up in c; the length owns c's low byte
			for (i = 0; i < blk_pos; i++) begin
				if (i < 4)
					lane_a += 32'(blk_buf[i]) << (8 * i);
				else if (i < 8)
					lane_b += 32'(blk_buf[i]) << (8 * (i - 4));
				else
					lane_c += 32'(blk_buf[i]) << (8 * (i - 7));
			end
			lookup2_mix();
			pending_hashes.push_back(lane_c);
			in_msg = 1'b0;
		end
	endfunction

	// Output side: random backpressure and in-order compare
	always @(posedge clk) begin
		logic [31:0] want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (pending_hashes.size() == 0) begin
					$error("hash_value: expected none, actual %08h", m_axis_tdata);
					fail_count++;
				end else begin
					want = pending_hashes.pop_front();
					if (m_axis_tdata !== want) begin
						$error("hash_value: expected %08h, actual %08h", want, m_axis_tdata);
						fail_count++;
					end
				end
			end
			m_axis_tready <= !gaps_on || ($urandom_range(0, 99) >= 20);
		end
	end

	// One input transfer; tvalid stays high into the next call unless it idles
	task automatic send_item(input logic [7:0] data_byte, input logic has_byte,
			input logic last);
		while (gaps_on && $urandom_range(0, 99) < 20) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= data_byte;
		s_axis_tuser  <= has_byte;
		s_axis_tlast  <= last;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		hash_predict(data_byte, has_byte, last);
		items_sent++;
	endtask

	// Drain all hashes, then let queued block jobs finish
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (pending_hashes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_seed(input logic [31:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		seed_reg = value;
	endtask

	// Message of random bytes; optional byte-less filler and byte-less last
	task automatic send_message(input int n_bytes, input bit tail_byte, input int noise_pct);
		int i;
		for (i = 0; i < n_bytes; i++) begin
			if ($urandom_range(0, 99) < noise_pct)
				send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
			send_item(8'($urandom_range(0, 255)), 1'b1, tail_byte && (i == n_bytes - 1));
		end
		if (!tail_byte || n_bytes == 0)
			send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
	endtask

	// Empty message under the reset seed, also after a filler transfer
	task automatic test_empty_message();
		send_item(8'h5a, 1'b0, 1'b1);
		send_item(8'ha5, 1'b0, 1'b0);
		send_item(8'h00, 1'b0, 1'b1);
		settle();
	endtask

	// Eleven tail bytes, all-ones and all-zeros alternating
	task automatic test_tail_bytes();
		int i;
		write_seed(32'hffff_ffff);
		for (i = 0; i < 11; i++)
			send_item(i[0] ? 8'h00 : 8'hff, 1'b1, i == 10);
		settle();
	endtask

	// A full block that also closes the message
	task automatic test_full_block_end();
		int i;
		write_seed(32'h0000_0000);
		for (i = 0; i < 12; i++)
			send_item(8'($urandom_range(0, 255)), 1'b1, i == 11);
		settle();
	endtask

	// Seed written inside a message only applies to the following one
	task automatic test_seed_mid_message();
		write_seed(32'h1234_5678);
		send_item(8'h81, 1'b1, 1'b0);
		send_item(8'h7e, 1'b1, 1'b0);
		settle();
		write_seed(32'hdead_beef);
		send_item(8'h3c, 1'b1, 1'b1);
		send_item(8'hc3, 1'b1, 1'b1);
		settle();
	endtask

	// Random messages; first stretch with no gaps, then gaps on both sides
	task automatic test_random();
		int n_bytes;
		int msg_count;
		int start;
		logic [31:0] next_seed;
		msg_count = 0;
		start = items_sent;
		gaps_on = 1'b0;
		while (items_sent - start < RANDOM_ITEMS) begin
			if (items_sent - start > 120)
				gaps_on = 1'b1;
			case ($urandom_range(0, 19))
				0:       n_bytes = $urandom_range(37, 80);
				1, 2, 3: n_bytes = $urandom_range(13, 36);
				default: n_bytes = $urandom_range(0, 12);
			endcase
			send_message(n_bytes, $urandom_range(0, 1), 10);
			msg_count++;
			// new seed every few messages, the extremes among them
			if (msg_count % 8 == 0) begin
				settle();
				case ((msg_count / 8) % 3)
					0:       next_seed = 32'h0000_0000;
					1:       next_seed = 32'hffff_ffff;
					default: next_seed = $urandom;
				endcase
				write_seed(next_seed);
			end
		end
		gaps_on = 1'b1;
	endtask

	initial begin
		arst_n        <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_wdata     <= 32'd0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= 8'd0;
		s_axis_tuser  <= 1'b0;
		s_axis_tlast  <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_message();
		test_tail_bytes();
		test_full_block_end();
		test_seed_mid_message();
		test_random();

		settle();
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

`default_nettype wire
